// ===== sv/djb2_string_hash_mod_assert.svh =====
// Assertion macros for the djb2 word hash modules; only djbh_div uses them.
`ifndef DJB2_STRING_HASH_MOD_ASSERT_SVH
`define DJB2_STRING_HASH_MOD_ASSERT_SVH

// Checked at every rising clock edge outside of reset.
`define DJBH_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked at every rising clock edge, also while reset is asserted.
`define DJBH_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/djbh_pkg.sv =====
// Package with the constants and types of the djb2 word hash block.
`timescale 1ns / 1ps
`default_nettype none
package djbh_pkg;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned IDX_W = 16;
	localparam int unsigned CFG_W = 17;
	localparam int unsigned SEED_VALUE = 5381;
	localparam int unsigned MUL_SHIFT = 5;
	localparam logic [CFG_W-1:0] BUCKET_RESET = 17'd1024;
	localparam logic [CFG_W-1:0] BUCKET_MAX = 17'd65536;
	localparam logic [CFG_W-1:0] BUCKET_MIN = 17'd1;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_RUN,
		DIV_DONE
	} div_state_t;
endpackage
`default_nettype wire

// ===== sv/djbh_if.sv =====
// Channel interfaces of the djb2 word hash block.
`timescale 1ns / 1ps
`default_nettype none
interface djbh_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	modport source (output valid, output char_byte, input ready);
	modport sink (input valid, input char_byte, output ready);
endinterface

interface djbh_idx_if;
	logic        valid;
	logic        ready;
	logic [15:0] bucket_index;
	modport source (output valid, output bucket_index, input ready);
	modport sink (input valid, input bucket_index, output ready);
endinterface

interface djbh_cfg_if;
	logic        valid;
	logic        ready;
	logic [16:0] bucket_count;
	modport source (output valid, output bucket_count, input ready);
	modport sink (input valid, input bucket_count, output ready);
endinterface
`default_nettype wire

// ===== sv/djb2_string_hash_mod.sv =====
// Top level of the djb2 word hash block with bucket reduction.
// The block takes one byte per transfer and can accept a byte in every cycle; the running
// hash (hash*33 + byte) is updated in the front part in the cycle the byte is taken. A zero
// byte ends the word and hands its hash, with the bucket count then in force, to a two-entry
// queue. The back part reduces each hash modulo the bucket count with a shift-subtract unit
// that retires one dividend bit per cycle and takes no new word until it is done; the result
// waits in an output register while the next word is reduced. Byte input stalls only when
// two finished words are queued, which happens when words come faster than they are reduced.
`timescale 1ns / 1ps
`default_nettype none
module djb2_string_hash_mod #(
	parameter int unsigned HASH_BITS = 64
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	djbh_byte_if.sink   chars,
	djbh_cfg_if.sink    cfg,
	djbh_idx_if.source  buckets
);
	import djbh_pkg::*;

	localparam int unsigned Q_W = HASH_BITS + CFG_W;

	logic           push;
	logic [Q_W-1:0] push_data;
	logic           full;
	logic           pop;
	logic [Q_W-1:0] pop_data;
	logic           empty;

	djbh_front #(.HASH_BITS(HASH_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.chars     (chars),
		.cfg       (cfg),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	djbh_fifo #(.WIDTH(Q_W)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	djbh_div #(.HASH_BITS(HASH_BITS)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop      (pop),
		.pop_data (pop_data),
		.empty    (empty),
		.buckets  (buckets)
	);
endmodule
`default_nettype wire

// ===== sv/djbh_fifo.sv =====
// Two-entry queue that carries finished word hashes to the divider.
`timescale 1ns / 1ps
`default_nettype none
module djbh_fifo #(
	parameter int unsigned WIDTH = 81
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      pop_data,
	output logic                  empty
);
	logic [WIDTH-1:0] mem_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       cnt_q;

	assign full = cnt_q[1];
	assign empty = (cnt_q == 2'd0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) begin
				wr_q <= ~wr_q;
			end
			if (pop && !empty) begin
				rd_q <= ~rd_q;
			end
			case ({push && !full, pop && !empty})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== sv/djbh_front.sv =====
// Front part: takes bytes, keeps the running hash and holds the bucket count.
`timescale 1ns / 1ps
`default_nettype none
module djbh_front #(
	parameter int unsigned HASH_BITS = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	djbh_byte_if.sink                          chars,
	djbh_cfg_if.sink                           cfg,
	output logic                               push,
	output logic [HASH_BITS+djbh_pkg::CFG_W-1:0] push_data,
	input  wire logic                          full
);
	import djbh_pkg::*;

	logic [HASH_BITS-1:0] hash_q;
	logic [HASH_BITS-1:0] hash_nxt;
	logic [CFG_W-1:0]     bucket_q;
	logic [CFG_W-1:0]     bucket_clamped;
	logic                 take;

	assign chars.ready = !full;
	assign cfg.ready = 1'b1;
	assign take = chars.valid && chars.ready;
	assign push = take && (chars.char_byte == 8'd0);
	assign push_data = {bucket_q, hash_q};
	assign hash_nxt = (hash_q << MUL_SHIFT) + hash_q
		+ {{(HASH_BITS-BYTE_W){1'b0}}, chars.char_byte};

	always_comb begin
		bucket_clamped = cfg.bucket_count;
		if (cfg.bucket_count == '0) begin
			bucket_clamped = BUCKET_MIN;
		end else if (cfg.bucket_count > BUCKET_MAX) begin
			bucket_clamped = BUCKET_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= HASH_BITS'(SEED_VALUE);
			bucket_q <= BUCKET_RESET;
		end else begin
			if (cfg.valid) begin
				bucket_q <= bucket_clamped;
			end
			if (take) begin
				hash_q <= push ? HASH_BITS'(SEED_VALUE) : hash_nxt;
			end
		end
	end
endmodule
`default_nettype wire

// ===== sv/djbh_div.sv =====
// Back part: shift-subtract remainder unit with an output register.
`timescale 1ns / 1ps
`default_nettype none
`include "djb2_string_hash_mod_assert.svh"
module djbh_div #(
	parameter int unsigned HASH_BITS = 64
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	output logic                                 pop,
	input  wire logic [HASH_BITS+djbh_pkg::CFG_W-1:0] pop_data,
	input  wire logic                            empty,
	djbh_idx_if.source                           buckets
);
	import djbh_pkg::*;

	localparam int unsigned CNT_W = $clog2(HASH_BITS);

	div_state_t           state_q;
	div_state_t           state_nxt;
	logic [HASH_BITS-1:0] dvd_q;
	logic [CFG_W-1:0]     div_q;
	logic [IDX_W-1:0]     rem_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [CFG_W-1:0]     trial;
	logic [CFG_W-1:0]     diff;
	logic [IDX_W-1:0]     rem_nxt;
	logic                 load_out;
	logic                 out_valid_q;
	logic [IDX_W-1:0]     res_q;

	assign trial = {rem_q, dvd_q[HASH_BITS-1]};
	assign diff = trial - div_q;
	assign rem_nxt = (trial >= div_q) ? diff[IDX_W-1:0] : trial[IDX_W-1:0];
	assign buckets.valid = out_valid_q;
	assign buckets.bucket_index = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		pop = 1'b0;
		load_out = 1'b0;
		case (state_q)
			DIV_IDLE: begin
				if (!empty) begin
					pop = 1'b1;
					state_nxt = DIV_RUN;
				end
			end
			DIV_RUN: begin
				if (cnt_q == '0) begin
					state_nxt = DIV_DONE;
				end
			end
			DIV_DONE: begin
				if (!out_valid_q || buckets.ready) begin
					load_out = 1'b1;
					state_nxt = DIV_IDLE;
				end
			end
			default: state_nxt = DIV_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			dvd_q <= pop_data[HASH_BITS-1:0];
			div_q <= pop_data[HASH_BITS +: CFG_W];
			rem_q <= '0;
		end else if (state_q == DIV_RUN) begin
			dvd_q <= dvd_q << 1;
			rem_q <= rem_nxt;
		end
		if (load_out) begin
			res_q <= rem_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cnt_q <= CNT_W'(HASH_BITS - 1);
			end else if (state_q == DIV_RUN) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (buckets.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`DJBH_ASSERT(a_rem_below_div, (state_q == DIV_RUN) |-> ({1'b0, rem_q} < div_q), "remainder not below divisor")
	`DJBH_ASSERT(a_div_nonzero, (state_q != DIV_IDLE) |-> (div_q != '0), "divisor is zero")
	`DJBH_ASSERT(a_run_ends, ((state_q == DIV_RUN) && (cnt_q == '0)) |=> (state_q == DIV_DONE), "division did not finish")
	`DJBH_ASSERT_ALWAYS(a_no_valid_in_reset, !arst_n |-> !out_valid_q, "result valid during reset")
endmodule
`default_nettype wire
